/* rtl/lhm_pkg.sv */
// ----------------------------------------------------------------------------
// lhm_pkg
// Shared types, constants and helpers for the latency histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

   localparam int NUM_BINS          = 10;
   localparam int BIN_IDX_WIDTH     = 4;
   localparam int NUM_BOUNDS        = NUM_BINS - 1;
   localparam int LATENCY_WIDTH     = 32;
   localparam int OUT_COUNT_WIDTH   = 32;
   localparam int OUT_TOTAL_WIDTH   = 40;
   localparam int SLOW_RUN_WIDTH    = 8;
   localparam int CSR_ADDR_WIDTH    = 4;
   localparam int CSR_DATA_WIDTH    = 8;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TOTAL_WIDTH_DEFAULT = 40;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SLOW_FIRST_BIN = 4'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SLOW_RUN_LIMIT = 4'd1;

   localparam logic [BIN_IDX_WIDTH-1:0]  SLOW_FIRST_BIN_RESET = 4'd7;
   localparam logic [SLOW_RUN_WIDTH-1:0] SLOW_RUN_LIMIT_RESET = 8'd5;

   localparam logic [BIN_IDX_WIDTH-1:0]  LAST_BIN_INDEX = 4'd9;
   localparam logic [SLOW_RUN_WIDTH-1:0] SLOW_RUN_MAX   = 8'd255;

   // lower bound of bins 1 to 9, in ms
   localparam logic [LATENCY_WIDTH-1:0] BIN_BOUNDS [NUM_BOUNDS] = '{
      32'd1, 32'd10, 32'd50, 32'd100, 32'd500,
      32'd1000, 32'd2000, 32'd5000, 32'd10000
   };

   localparam logic KIND_SAMPLE       = 1'b0;
   localparam logic KIND_INTERVAL_END = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic [LATENCY_WIDTH-1:0] latency_ms;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_IDX_WIDTH-1:0]   bin_index;
      logic [OUT_COUNT_WIDTH-1:0] interval_count;
      logic [OUT_TOTAL_WIDTH-1:0] total_count;
      logic [SLOW_RUN_WIDTH-1:0]  slow_run;
      logic                       stop;
      logic                       last;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_REPORT
   } ctrl_state_type;

   typedef struct packed {
      logic sample;   // count one sample
      logic start;    // interval end taken: update slow run, rewind bin pointer
      logic emit;     // load one bin into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_bin;
   } dp_status_type;

   // bounds are bin-sorted, so the bin is the number of bounds at or below t
   function automatic logic [BIN_IDX_WIDTH-1:0] pick_bin(
      input logic [LATENCY_WIDTH-1:0] t
   );
      logic [BIN_IDX_WIDTH-1:0] b;
      b = '0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         if (t >= BIN_BOUNDS[i]) begin
            b = b + 1'b1;
         end
      end
      return b;
   endfunction

endpackage

/* rtl/lhm_ctrl.sv */
// ----------------------------------------------------------------------------
// lhm_ctrl
// Controller: takes transactions and sequences the ten-bin report.
// ----------------------------------------------------------------------------
module lhm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_ready,
   input  lhm_pkg::dp_status_type status,
   output lhm_pkg::ctrl_cmd_type  cmd
);
   import lhm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_INTERVAL_END) begin
                  cmd.start = 1'b1;
                  state_in  = ST_REPORT;
               end else begin
                  cmd.sample = 1'b1;
               end
            end
         end
         ST_REPORT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.last_bin) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/lhm_datapath.sv */
// ----------------------------------------------------------------------------
// lhm_datapath
// Bin counters, totals, slow-run tracking, registers and output register.
// ----------------------------------------------------------------------------
module lhm_datapath #(
   parameter int COUNT_WIDTH = lhm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int TOTAL_WIDTH = lhm_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lhm_pkg::ctrl_cmd_type                  cmd,
   output lhm_pkg::dp_status_type                 status,
   input  logic [lhm_pkg::LATENCY_WIDTH-1:0]      latency_ms,
   input  logic                                   csr_we,
   input  logic [lhm_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [lhm_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output lhm_pkg::rsp_payload_type               rsp_payload
);
   import lhm_pkg::*;

   localparam int MAX_WIDTH = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;
   localparam int SUM_WIDTH = MAX_WIDTH + 1;

   logic [COUNT_WIDTH-1:0]    interval_ff [NUM_BINS];
   logic [TOTAL_WIDTH-1:0]    total_ff    [NUM_BINS];
   logic [BIN_IDX_WIDTH-1:0]  idx_ff;
   logic [BIN_IDX_WIDTH-1:0]  slow_first_bin_ff;
   logic [SLOW_RUN_WIDTH-1:0] slow_run_limit_ff;
   logic [SLOW_RUN_WIDTH-1:0] slow_run_ff;
   logic [SLOW_RUN_WIDTH-1:0] slow_run_in;
   logic                      stop_ff;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff;
   rsp_payload_type           rsp_payload_in;

   logic [BIN_IDX_WIDTH-1:0]  sample_bin;
   logic [BIN_IDX_WIDTH-1:0]  rd_addr;
   logic [COUNT_WIDTH-1:0]    rd_count;
   logic [COUNT_WIDTH-1:0]    inc_count;
   logic [TOTAL_WIDTH-1:0]    rd_total;
   logic [SUM_WIDTH-1:0]      tot_sum;
   logic [TOTAL_WIDTH-1:0]    tot_new;
   logic                      slow;

   assign sample_bin = pick_bin(latency_ms);
   // a read port on the interval bins, shared by counting and reporting (the slow check reads every bin)
   assign rd_addr    = cmd.emit ? idx_ff : sample_bin;
   assign rd_count   = interval_ff[rd_addr];
   assign inc_count  = (rd_count == {COUNT_WIDTH{1'b1}}) ? rd_count : rd_count + 1'b1;
   assign rd_total   = total_ff[idx_ff];

   // saturating total update
   always_comb begin
      tot_sum = SUM_WIDTH'(rd_total) + SUM_WIDTH'(rd_count);
      if (tot_sum > SUM_WIDTH'({TOTAL_WIDTH{1'b1}})) begin
         tot_new = {TOTAL_WIDTH{1'b1}};
      end else begin
         tot_new = tot_sum[TOTAL_WIDTH-1:0];
      end
   end

   // slow interval: any nonzero bin at or past the configured first bin
   always_comb begin
      slow = 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
         if ((BIN_IDX_WIDTH'(i) >= slow_first_bin_ff) && (interval_ff[i] != '0)) begin
            slow = 1'b1;
         end
      end
      if (!slow) begin
         slow_run_in = '0;
      end else if (slow_run_ff == SLOW_RUN_MAX) begin
         slow_run_in = slow_run_ff;
      end else begin
         slow_run_in = slow_run_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_payload_in.bin_index      = idx_ff;
      rsp_payload_in.interval_count = OUT_COUNT_WIDTH'(rd_count);
      rsp_payload_in.total_count    = OUT_TOTAL_WIDTH'(tot_new);
      rsp_payload_in.slow_run       = slow_run_ff;
      rsp_payload_in.stop           = stop_ff;
      rsp_payload_in.last           = (idx_ff == LAST_BIN_INDEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            interval_ff[i] <= '0;
            total_ff[i]    <= '0;
         end
      end else if (cmd.sample) begin
         interval_ff[sample_bin] <= inc_count;
      end else if (cmd.emit) begin
         interval_ff[idx_ff] <= '0;
         total_ff[idx_ff]    <= tot_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         slow_run_ff <= '0;
         stop_ff     <= 1'b0;
      end else if (cmd.start) begin
         idx_ff      <= '0;
         slow_run_ff <= slow_run_in;
         stop_ff     <= (slow_run_in > slow_run_limit_ff);
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_first_bin_ff <= SLOW_FIRST_BIN_RESET;
         slow_run_limit_ff <= SLOW_RUN_LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_SLOW_FIRST_BIN) begin
            slow_first_bin_ff <= csr_wdata[BIN_IDX_WIDTH-1:0];
         end
         if (csr_addr == CSR_SLOW_RUN_LIMIT) begin
            slow_run_limit_ff <= csr_wdata[SLOW_RUN_WIDTH-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.last_bin = (idx_ff == LAST_BIN_INDEX);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;

endmodule

/* rtl/latency_histogram_monitor.sv */
// ----------------------------------------------------------------------------
// latency_histogram_monitor
// Response-time histogram over ten fixed bins with slow-interval watch.
// ----------------------------------------------------------------------------
// A sample transaction (kind 0) is taken and counted into its bin, so
// samples stream at one per cycle while no report is in progress. An
// interval-end transaction (kind 1) is taken, then the controller reports
// the ten bins one per cycle through the output register while the sink
// keeps up, adding each interval count into its total and clearing it;
// the next transaction is taken once the last bin is loaded, and result
// side stalls hold the report back. Every counter saturates. Registers:
// index 0 is the first bin that marks an interval as slow, index 1 the run
// limit that raises stop; write them only while no report is in progress.
// ----------------------------------------------------------------------------
module latency_histogram_monitor #(
   parameter int COUNT_WIDTH = lhm_pkg::COUNT_WIDTH_DEFAULT,
   parameter int TOTAL_WIDTH = lhm_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lhm_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lhm_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_we,
   input  logic [lhm_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [lhm_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import lhm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lhm_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .latency_ms  (req_payload.latency_ms),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
